>>> rtl/core/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// Request and response types, operation, condition and status codes, and the
// pipeline stage types of the integer execute unit.
// ----------------------------------------------------------------------------
package ialu_pkg;

	localparam int unsigned WORD_W = 32;

	localparam logic [4:0] FN_ADD    = 5'd0;
	localparam logic [4:0] FN_SUB    = 5'd1;
	localparam logic [4:0] FN_AND    = 5'd2;
	localparam logic [4:0] FN_OR     = 5'd3;
	localparam logic [4:0] FN_XOR    = 5'd4;
	localparam logic [4:0] FN_SLL    = 5'd5;
	localparam logic [4:0] FN_SRL    = 5'd6;
	localparam logic [4:0] FN_SRA    = 5'd7;
	localparam logic [4:0] FN_SETC   = 5'd8;
	localparam logic [4:0] FN_MUL    = 5'd9;
	localparam logic [4:0] FN_MULHU  = 5'd10;
	localparam logic [4:0] FN_MULHS  = 5'd11;
	localparam logic [4:0] FN_DIVU   = 5'd12;
	localparam logic [4:0] FN_REMU   = 5'd13;
	localparam logic [4:0] FN_DIV    = 5'd14;
	localparam logic [4:0] FN_REM    = 5'd15;
	localparam logic [4:0] FN_DIV64U = 5'd16;
	localparam logic [4:0] FN_REM64U = 5'd17;
	localparam logic [4:0] FN_DIV64S = 5'd18;
	localparam logic [4:0] FN_REM64S = 5'd19;
	localparam logic [4:0] FN_BRANCH = 5'd20;

	localparam logic [3:0] CC_FALSE = 4'd0;
	localparam logic [3:0] CC_TRUE  = 4'd1;
	localparam logic [3:0] CC_EQ    = 4'd2;
	localparam logic [3:0] CC_NE    = 4'd3;
	localparam logic [3:0] CC_LT    = 4'd4;
	localparam logic [3:0] CC_GE    = 4'd5;
	localparam logic [3:0] CC_LE    = 4'd6;
	localparam logic [3:0] CC_GT    = 4'd7;
	localparam logic [3:0] CC_LTU   = 4'd8;
	localparam logic [3:0] CC_GEU   = 4'd9;
	localparam logic [3:0] CC_LEU   = 4'd10;
	localparam logic [3:0] CC_GTU   = 4'd11;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_CC  = 2'd1;
	localparam logic [1:0] ST_DIV0    = 2'd2;
	localparam logic [1:0] ST_OVF     = 2'd3;

	localparam logic [1:0] MS_NONE = 2'd0;
	localparam logic [1:0] MS_LOW  = 2'd1;
	localparam logic [1:0] MS_HU   = 2'd2;
	localparam logic [1:0] MS_HS   = 2'd3;

	typedef struct packed {
		logic [4:0]        func;
		logic [3:0]        cond_code;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
		logic [WORD_W-1:0] dividend_high;
		logic [WORD_W-1:0] branch_target;
		logic [WORD_W-1:0] sequential_pc;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic [WORD_W-1:0] next_pc;
		logic              taken;
		logic [1:0]        status;
	} rsp_t;

	// control that rides along with each request
	typedef struct packed {
		logic is_div;   // nonzero divisor, divider result overrides
		logic rem_op;
		logic chk_u;    // 64/32 unsigned quotient range check
		logic chk_s;    // 64/32 signed quotient range check
		logic qneg;
		logic nneg;
		rsp_t rsp;
	} meta_t;

	// restoring divider state: partial remainder, dividend bits / quotient
	typedef struct packed {
		logic [WORD_W-1:0]   rem;
		logic [2*WORD_W-1:0] nq;
		logic [WORD_W-1:0]   dvs;
	} div_t;

endpackage

>>> rtl/core/integer_alu_mul_div_branch.sv
// ----------------------------------------------------------------------------
// integer_alu_mul_div_branch
// Pipelined 32-bit execute unit: ALU, compares, multiply, 64/32 divide, branch.
// ----------------------------------------------------------------------------
// Every request takes the same path through NDIV+2 register stages, so one
// request enters per cycle while req_stall is low, and responses leave in
// order (two quotient bits per divider stage by default). Stage one
// decodes, evaluates ALU, compare and branch results, forms divide
// magnitudes and runs the 32x32 multiplier. The next NDIV stages are an
// unrolled restoring divider, DIV_STEPS_PER_STAGE quotient bits each; the
// first of them also finishes the multiply high words. The last stage
// restores quotient and remainder signs, checks 64/32 quotient range and
// holds the response. The pipeline collapses bubbles: a stage advances
// whenever it is empty or the stage after it advances, so a stalled
// response blocks new requests only once every stage is full.
// ----------------------------------------------------------------------------
module integer_alu_mul_div_branch #(
	parameter int unsigned DIV_STEPS_PER_STAGE = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ialu_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ialu_pkg::rsp_t  rsp
);

	localparam int unsigned W    = ialu_pkg::WORD_W;
	localparam int unsigned NDIV = (2 * W) / DIV_STEPS_PER_STAGE;
	localparam int unsigned NST  = NDIV + 2;

	logic [NST-1:0]  v_s;
	logic [NST:0]    adv;
	ialu_pkg::meta_t meta_s [NST];
	ialu_pkg::meta_t meta_d [NST];
	ialu_pkg::div_t  div_s  [NDIV+1];
	ialu_pkg::div_t  div_d  [NDIV+1];

	logic [2*W-1:0] prod_s1;
	logic [W-1:0]   corr_s1;
	logic [1:0]     msel_s1;
	logic [2*W-1:0] prod_d;
	logic [W-1:0]   corr_d;
	logic [1:0]     msel_d;

	// one restoring step: shift in a dividend bit, subtract if it fits
	function automatic ialu_pkg::div_t div_step(input ialu_pkg::div_t x);
		ialu_pkg::div_t y;
		logic [W:0]     t;
		logic [W:0]     diff;
		t    = {x.rem, x.nq[2*W-1]};
		diff = t - {1'b0, x.dvs};
		y    = x;
		if (t >= {1'b0, x.dvs}) begin
			y.rem = diff[W-1:0];
			y.nq  = {x.nq[2*W-2:0], 1'b1};
		end else begin
			y.rem = t[W-1:0];
			y.nq  = {x.nq[2*W-2:0], 1'b0};
		end
		return y;
	endfunction

	// stage one: decode, ALU, compare, branch and operand preparation
	always_comb begin
		logic [W-1:0]   a, b;
		logic           bad, cnd, sgn, wide, dneg;
		logic [2*W-1:0] n;
		logic [W-1:0]   res;
		a = req.operand_a;
		b = req.operand_b;
		bad = 1'b0;
		case (req.cond_code)
			ialu_pkg::CC_FALSE: cnd = 1'b0;
			ialu_pkg::CC_TRUE:  cnd = 1'b1;
			ialu_pkg::CC_EQ:    cnd = a == b;
			ialu_pkg::CC_NE:    cnd = a != b;
			ialu_pkg::CC_LT:    cnd = $signed(a) < $signed(b);
			ialu_pkg::CC_GE:    cnd = $signed(a) >= $signed(b);
			ialu_pkg::CC_LE:    cnd = $signed(a) <= $signed(b);
			ialu_pkg::CC_GT:    cnd = $signed(a) > $signed(b);
			ialu_pkg::CC_LTU:   cnd = a < b;
			ialu_pkg::CC_GEU:   cnd = a >= b;
			ialu_pkg::CC_LEU:   cnd = a <= b;
			ialu_pkg::CC_GTU:   cnd = a > b;
			default: begin
				cnd = 1'b0;
				bad = 1'b1;
			end
		endcase

		meta_d[0]     = '0;
		msel_d        = ialu_pkg::MS_NONE;
		res           = '0;
		case (req.func)
			ialu_pkg::FN_ADD:  res = a + b;
			ialu_pkg::FN_SUB:  res = a - b;
			ialu_pkg::FN_AND:  res = a & b;
			ialu_pkg::FN_OR:   res = a | b;
			ialu_pkg::FN_XOR:  res = a ^ b;
			ialu_pkg::FN_SLL:  res = a << b[4:0];
			ialu_pkg::FN_SRL:  res = a >> b[4:0];
			ialu_pkg::FN_SRA:  res = W'($signed(a) >>> b[4:0]);
			ialu_pkg::FN_SETC: begin
				res = {{(W-1){1'b0}}, cnd};
				meta_d[0].rsp.status = bad ? ialu_pkg::ST_BAD_CC : ialu_pkg::ST_OK;
			end
			ialu_pkg::FN_MUL:   msel_d = ialu_pkg::MS_LOW;
			ialu_pkg::FN_MULHU: msel_d = ialu_pkg::MS_HU;
			ialu_pkg::FN_MULHS: msel_d = ialu_pkg::MS_HS;
			ialu_pkg::FN_BRANCH: begin
				meta_d[0].rsp.taken   = cnd;
				meta_d[0].rsp.next_pc = cnd ? req.branch_target : req.sequential_pc;
				meta_d[0].rsp.status  = bad ? ialu_pkg::ST_BAD_CC : ialu_pkg::ST_OK;
			end
			default: res = '0;
		endcase

		// divide operand preparation
		sgn  = req.func inside {ialu_pkg::FN_DIV, ialu_pkg::FN_REM,
		                        ialu_pkg::FN_DIV64S, ialu_pkg::FN_REM64S};
		wide = req.func inside {[ialu_pkg::FN_DIV64U:ialu_pkg::FN_REM64S]};
		if (wide)
			n = {req.dividend_high, a};
		else
			n = {{W{sgn & a[W-1]}}, a};
		meta_d[0].nneg = sgn & n[2*W-1];
		dneg           = sgn & b[W-1];
		meta_d[0].qneg = meta_d[0].nneg ^ dneg;
		div_d[0].rem   = '0;
		div_d[0].nq    = meta_d[0].nneg ? (-n) : n;
		div_d[0].dvs   = dneg ? (-b) : b;
		meta_d[0].rem_op = req.func inside {ialu_pkg::FN_REMU, ialu_pkg::FN_REM,
		                                    ialu_pkg::FN_REM64U, ialu_pkg::FN_REM64S};
		meta_d[0].chk_u  = req.func == ialu_pkg::FN_DIV64U;
		meta_d[0].chk_s  = req.func == ialu_pkg::FN_DIV64S;
		if (req.func inside {[ialu_pkg::FN_DIVU:ialu_pkg::FN_REM64S]}) begin
			if (b == '0) begin
				// divide by zero: all ones quotient, remainder is the low word
				res = meta_d[0].rem_op ? a : '1;
				meta_d[0].rsp.status = ialu_pkg::ST_DIV0;
			end else begin
				meta_d[0].is_div = 1'b1;
			end
		end
		meta_d[0].rsp.result = res;

		prod_d = a * b;
		corr_d = (a[W-1] ? b : '0) + (b[W-1] ? a : '0);
	end

	// divider stages; the first one also finishes the multiply
	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		always_comb begin
			ialu_pkg::div_t x;
			meta_d[k] = meta_s[k-1];
			x = div_s[k-1];
			for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
				x = div_step(x);
			div_d[k] = x;
			if (k == 1) begin
				case (msel_s1)
					ialu_pkg::MS_LOW: meta_d[k].rsp.result = prod_s1[W-1:0];
					ialu_pkg::MS_HU:  meta_d[k].rsp.result = prod_s1[2*W-1:W];
					ialu_pkg::MS_HS:  meta_d[k].rsp.result = prod_s1[2*W-1:W] - corr_s1;
					default: ;
				endcase
			end
		end
	end

	// last stage: restore signs, check quotient range
	always_comb begin
		logic [2*W-1:0] qm, qs;
		logic [W-1:0]   rm, rs;
		logic           ovf;
		meta_d[NST-1] = meta_s[NDIV];
		qm  = div_s[NDIV].nq;
		rm  = div_s[NDIV].rem;
		qs  = meta_s[NDIV].qneg ? (-qm) : qm;
		rs  = meta_s[NDIV].nneg ? (-rm) : rm;
		ovf = (meta_s[NDIV].chk_u && (qm[2*W-1:W] != '0)) ||
		      (meta_s[NDIV].chk_s && (meta_s[NDIV].qneg ?
		        (qm > {{(W+1){1'b0}}, {(W-1){1'b0}}} + (2*W)'(64'h8000_0000)) :
		        (qm > (2*W)'(64'h7fff_ffff))));
		if (meta_s[NDIV].is_div) begin
			meta_d[NST-1].rsp.result = meta_s[NDIV].rem_op ? rs : qs[W-1:0];
			meta_d[NST-1].rsp.status = ovf ? ialu_pkg::ST_OVF : ialu_pkg::ST_OK;
		end
	end

	// advance a stage when it is empty or the next stage advances
	always_comb begin
		adv[NST] = !rsp_stall;
		for (int k = NST - 1; k >= 0; k--)
			adv[k] = !v_s[k] || adv[k+1];
	end

	assign req_stall = !adv[0];
	assign rsp_valid = v_s[NST-1];
	assign rsp       = meta_s[NST-1].rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (adv[0])
				v_s[0] <= req_valid;
			for (int k = 1; k < NST; k++)
				if (adv[k])
					v_s[k] <= v_s[k-1];
		end
	end

	// payload: load on advance, hold otherwise
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			meta_s[0] <= meta_d[0];
			div_s[0]  <= div_d[0];
			prod_s1   <= prod_d;
			corr_s1   <= corr_d;
			msel_s1   <= msel_d;
		end
		for (int k = 1; k < NST; k++)
			if (adv[k])
				meta_s[k] <= meta_d[k];
		for (int k = 1; k <= NDIV; k++)
			if (adv[k])
				div_s[k] <= div_d[k];
	end

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_stall |-> !req_stall)
		else $error("request stalled while response side is free");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_stall && (&v_s)) |-> req_stall)
		else $error("request accepted into a full stalled pipeline");

	a_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.taken) |-> (rsp.status == ialu_pkg::ST_OK))
		else $error("branch taken with bad condition code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[NST-1] && rsp_stall) |=> v_s[NST-1])
		else $error("stalled response dropped");

endmodule

>>> dv/integer_alu_mul_div_branch_test.sv
// ----------------------------------------------------------------------------
// integer_alu_mul_div_branch_test
// Drives operations of every kind into the execute unit and checks each
// response, field by field and in order, against a local predictor or a typed-in expectation.
// ----------------------------------------------------------------------------
module integer_alu_mul_div_branch_test;

	localparam int NUM_RANDOM    = 2000;
	localparam int LATENCY       = 40;
	localparam int WATCHDOG_MAX  = 5000;
	localparam int HOLDOFF_LEN   = 200;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	ialu_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	ialu_pkg::rsp_t rsp;

	integer_alu_mul_div_branch u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// one row of the directed table; check_fixed marks rows whose response
	// is typed in here instead of taken from the predictor
	typedef struct {
		ialu_pkg::req_t rq;
		bit             check_fixed;
		ialu_pkg::rsp_t fixed;
	} stim_row_t;

	ialu_pkg::rsp_t pending_rsp_q[$];
	int   error_count;
	bit   drive_done;
	bit   no_idle;
	bit   holdoff;
	int   idle_cycles;

	initial begin
		clk = 1'b0;
	end
	always begin
		#6 clk = ~clk;
	end

	function automatic bit eval_cond(logic [3:0] cc, logic [31:0] a, logic [31:0] b,
		output bit bad);
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		sa = a;
		sb = b;
		bad = 1'b0;
		case (cc)
			ialu_pkg::CC_FALSE: return 1'b0;
			ialu_pkg::CC_TRUE:  return 1'b1;
			ialu_pkg::CC_EQ:    return a == b;
			ialu_pkg::CC_NE:    return a != b;
			ialu_pkg::CC_LT:    return sa < sb;
			ialu_pkg::CC_GE:    return sa >= sb;
			ialu_pkg::CC_LE:    return sa <= sb;
			ialu_pkg::CC_GT:    return sa > sb;
			ialu_pkg::CC_LTU:   return a < b;
			ialu_pkg::CC_GEU:   return a >= b;
			ialu_pkg::CC_LEU:   return a <= b;
			ialu_pkg::CC_GTU:   return a > b;
			default: begin
				bad = 1'b1;
				return 1'b0;
			end
		endcase
	endfunction

	// compute the response the unit owes for one request
	function automatic ialu_pkg::rsp_t execute_op(ialu_pkg::req_t r);
		ialu_pkg::rsp_t o;
		bit bad;
		bit is_64;
		bit is_quot;
		logic [4:0] sh;
		logic [63:0] prod;
		logic [63:0] num;
		logic [63:0] num_mag;
		logic [63:0] dvs_mag;
		logic [63:0] q_mag;
		logic [63:0] r_mag;
		logic [63:0] q_full;
		logic [63:0] r_full;
		bit nneg;
		bit dneg;
		bit qneg;
		o = '0;
		sh = r.operand_b[4:0];
		case (r.func)
			ialu_pkg::FN_ADD: o.result = r.operand_a + r.operand_b;
			ialu_pkg::FN_SUB: o.result = r.operand_a - r.operand_b;
			ialu_pkg::FN_AND: o.result = r.operand_a & r.operand_b;
			ialu_pkg::FN_OR:  o.result = r.operand_a | r.operand_b;
			ialu_pkg::FN_XOR: o.result = r.operand_a ^ r.operand_b;
			ialu_pkg::FN_SLL: o.result = r.operand_a << sh;
			ialu_pkg::FN_SRL: o.result = r.operand_a >> sh;
			ialu_pkg::FN_SRA: o.result = $signed(r.operand_a) >>> sh;
			ialu_pkg::FN_SETC: begin
				o.result = {31'b0, eval_cond(r.cond_code, r.operand_a, r.operand_b, bad)};
				o.status = bad ? ialu_pkg::ST_BAD_CC : ialu_pkg::ST_OK;
			end
			ialu_pkg::FN_MUL: o.result = r.operand_a * r.operand_b;
			ialu_pkg::FN_MULHU: begin
				prod = {32'b0, r.operand_a} * {32'b0, r.operand_b};
				o.result = prod[63:32];
			end
			ialu_pkg::FN_MULHS: begin
				prod = $signed({{32{r.operand_a[31]}}, r.operand_a})
					* $signed({{32{r.operand_b[31]}}, r.operand_b});
				o.result = prod[63:32];
			end
			ialu_pkg::FN_DIVU, ialu_pkg::FN_REMU, ialu_pkg::FN_DIV64U,
			ialu_pkg::FN_REM64U: begin
				is_64 = r.func >= ialu_pkg::FN_DIV64U;
				is_quot = r.func == ialu_pkg::FN_DIVU || r.func == ialu_pkg::FN_DIV64U;
				num = is_64 ? {r.dividend_high, r.operand_a} : {32'b0, r.operand_a};
				if (r.operand_b == 0) begin
					o.result = is_quot ? 32'hffff_ffff : r.operand_a;
					o.status = ialu_pkg::ST_DIV0;
				end else if (is_quot) begin
					q_full = num / {32'b0, r.operand_b};
					o.result = q_full[31:0];
					if (q_full[63:32] != 0) o.status = ialu_pkg::ST_OVF;
				end else begin
					r_full = num % {32'b0, r.operand_b};
					o.result = r_full[31:0];
				end
			end
			ialu_pkg::FN_DIV, ialu_pkg::FN_REM, ialu_pkg::FN_DIV64S,
			ialu_pkg::FN_REM64S: begin
				is_64 = r.func >= ialu_pkg::FN_DIV64S;
				is_quot = r.func == ialu_pkg::FN_DIV || r.func == ialu_pkg::FN_DIV64S;
				num = is_64 ? {r.dividend_high, r.operand_a}
					: {{32{r.operand_a[31]}}, r.operand_a};
				if (r.operand_b == 0) begin
					o.result = is_quot ? 32'hffff_ffff : r.operand_a;
					o.status = ialu_pkg::ST_DIV0;
				end else begin
					nneg = num[63];
					dneg = r.operand_b[31];
					qneg = nneg != dneg;
					num_mag = nneg ? -num : num;
					dvs_mag = dneg ? {32'b0, -r.operand_b} : {32'b0, r.operand_b};
					q_mag = num_mag / dvs_mag;
					r_mag = num_mag % dvs_mag;
					q_full = qneg ? -q_mag : q_mag;
					r_full = nneg ? -r_mag : r_mag;
					if (is_quot) begin
						o.result = q_full[31:0];
						if (is_64 && (qneg ? q_mag > 64'h8000_0000 : q_mag > 64'h7fff_ffff))
							o.status = ialu_pkg::ST_OVF;
					end else begin
						o.result = r_full[31:0];
					end
				end
			end
			ialu_pkg::FN_BRANCH: begin
				o.taken = eval_cond(r.cond_code, r.operand_a, r.operand_b, bad);
				o.status = bad ? ialu_pkg::ST_BAD_CC : ialu_pkg::ST_OK;
				o.next_pc = o.taken ? r.branch_target : r.sequential_pc;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return $urandom_range(0, 40);
			5: return -$urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic ialu_pkg::req_t random_request();
		ialu_pkg::req_t r;
		r.func = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, 20));
		r.cond_code = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
			: 4'($urandom_range(0, 11));
		r.operand_a = pick_word();
		r.operand_b = pick_word();
		case ($urandom_range(0, 3))
			0: r.dividend_high = 32'h0;
			1: r.dividend_high = 32'hffff_ffff;
			default: r.dividend_high = pick_word();
		endcase
		// keep many 64/32 divides in range by using a small high word
		if ((r.func inside {[ialu_pkg::FN_DIV64U:ialu_pkg::FN_REM64S]})
			&& $urandom_range(0, 1) && r.operand_b != 0)
			r.dividend_high = $urandom % ((r.operand_b >> 1) + 1);
		r.branch_target = $urandom;
		r.sequential_pc = $urandom;
		return r;
	endfunction

	function automatic stim_row_t row(logic [4:0] fn, logic [3:0] cc, logic [31:0] a,
		logic [31:0] b, logic [31:0] hi, bit fixed_chk, logic [31:0] res,
		logic [31:0] npc, logic tk, logic [1:0] st);
		stim_row_t s;
		s.rq = '{fn, cc, a, b, hi, 32'h0000_1000, 32'h0000_2004};
		s.check_fixed = fixed_chk;
		s.fixed = '{res, npc, tk, st};
		return s;
	endfunction

	stim_row_t directed_rows[$];

	// offer one request and hold it until it is accepted
	task automatic send_request(ialu_pkg::req_t r);
		while (!no_idle && $urandom_range(0, 99) < 21) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// sender
	initial begin
		ialu_pkg::rsp_t expected;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b1;
		error_count = 0;
		drive_done = 1'b0;
		no_idle = 1'b0;
		holdoff = 1'b0;
		directed_rows = '{
			row(ialu_pkg::FN_ADD, ialu_pkg::CC_FALSE, 32'hffff_ffff, 32'h1, 32'h0, 1'b1,
				32'h0, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_SUB, ialu_pkg::CC_FALSE, 32'h0, 32'h1, 32'h0, 1'b1,
				32'hffff_ffff, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_AND, ialu_pkg::CC_FALSE, 32'hf0f0_f0f0, 32'hffff_0000, 32'h0,
				1'b0, 32'h0, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_OR, ialu_pkg::CC_FALSE, 32'hf0f0_f0f0, 32'h0f0f_0000, 32'h0,
				1'b0, 32'h0, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_XOR, ialu_pkg::CC_FALSE, 32'hffff_ffff, 32'h5555_5555, 32'h0,
				1'b0, 32'h0, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_SLL, ialu_pkg::CC_FALSE, 32'h1, 32'h3f, 32'h0, 1'b1,
				32'h8000_0000, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_SRL, ialu_pkg::CC_FALSE, 32'h8000_0000, 32'h1f, 32'h0, 1'b1,
				32'h1, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_SRA, ialu_pkg::CC_FALSE, 32'h8000_0000, 32'h1f, 32'h0, 1'b1,
				32'hffff_ffff, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_SETC, ialu_pkg::CC_LT, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
				1'b1, 32'h1, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_SETC, ialu_pkg::CC_LTU, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
				1'b1, 32'h0, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_SETC, 4'd15, 32'h0, 32'h0, 32'h0, 1'b1,
				32'h0, 32'h0, 1'b0, ialu_pkg::ST_BAD_CC),
			row(ialu_pkg::FN_MUL, ialu_pkg::CC_FALSE, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
				1'b1, 32'h1, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_MULHU, ialu_pkg::CC_FALSE, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
				1'b1, 32'hffff_fffe, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_MULHS, ialu_pkg::CC_FALSE, 32'h8000_0000, 32'h8000_0000, 32'h0,
				1'b1, 32'h4000_0000, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_DIVU, ialu_pkg::CC_FALSE, 32'h1234, 32'h0, 32'h0, 1'b1,
				32'hffff_ffff, 32'h0, 1'b0, ialu_pkg::ST_DIV0),
			row(ialu_pkg::FN_REMU, ialu_pkg::CC_FALSE, 32'h1234, 32'h0, 32'h0, 1'b1,
				32'h1234, 32'h0, 1'b0, ialu_pkg::ST_DIV0),
			row(ialu_pkg::FN_DIV, ialu_pkg::CC_FALSE, 32'h8000_0000, 32'hffff_ffff, 32'h0,
				1'b1, 32'h8000_0000, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_REM, ialu_pkg::CC_FALSE, 32'hffff_fff9, 32'h2, 32'h0, 1'b1,
				32'hffff_ffff, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_DIV64U, ialu_pkg::CC_FALSE, 32'h0, 32'h1, 32'h1, 1'b1,
				32'h0, 32'h0, 1'b0, ialu_pkg::ST_OVF),
			row(ialu_pkg::FN_REM64U, ialu_pkg::CC_FALSE, 32'h5, 32'h3, 32'h2, 1'b0,
				32'h0, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_DIV64S, ialu_pkg::CC_FALSE, 32'h0, 32'hffff_ffff, 32'h8000_0000,
				1'b1, 32'h0, 32'h0, 1'b0, ialu_pkg::ST_OVF),
			row(ialu_pkg::FN_REM64S, ialu_pkg::CC_FALSE, 32'h7, 32'hffff_fffd, 32'hffff_ffff,
				1'b0, 32'h0, 32'h0, 1'b0, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_BRANCH, ialu_pkg::CC_EQ, 32'h5, 32'h5, 32'h0, 1'b1,
				32'h0, 32'h0000_1000, 1'b1, ialu_pkg::ST_OK),
			row(ialu_pkg::FN_BRANCH, 4'd12, 32'h5, 32'h5, 32'h0, 1'b1,
				32'h0, 32'h0000_2004, 1'b0, ialu_pkg::ST_BAD_CC),
			row(5'd31, ialu_pkg::CC_TRUE, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b1,
				32'h0, 32'h0, 1'b0, ialu_pkg::ST_OK)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			expected = directed_rows[i].check_fixed ? directed_rows[i].fixed
				: execute_op(directed_rows[i].rq);
			pending_rsp_q.push_back(expected);
			send_request(directed_rows[i].rq);
		end
		for (int n = 0; n < NUM_RANDOM; n++) begin
			ialu_pkg::req_t r;
			// run a stretch with no idling on either side
			no_idle = (n >= 800 && n < 1100);
			r = random_request();
			pending_rsp_q.push_back(execute_op(r));
			send_request(r);
		end
		req_valid <= 1'b0;
		drive_done = 1'b1;
	end

	// receiver: random stalls, plus one long hold-off to fill the pipeline
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!holdoff && pending_rsp_q.size() > 16 && !drive_done) begin
				holdoff = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLDOFF_LEN) @(posedge clk);
			end
			rsp_stall <= !no_idle && ($urandom_range(0, 99) < 21);
		end
	end

	// check each accepted response against the oldest expectation
	always @(posedge clk) begin
		ialu_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp_q.size() == 0) begin
				$error("unexpected response %h", rsp);
				error_count++;
			end else begin
				want = pending_rsp_q.pop_front();
				if (rsp.result !== want.result) begin
					$error("result: expected %h, got %h", want.result, rsp.result);
					error_count++;
				end
				if (rsp.next_pc !== want.next_pc) begin
					$error("next_pc: expected %h, got %h", want.next_pc, rsp.next_pc);
					error_count++;
				end
				if (rsp.taken !== want.taken) begin
					$error("taken: expected %b, got %b", want.taken, rsp.taken);
					error_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake, and the end of the run
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("RESULT: ERROR");
				$finish;
			end
			if (drive_done && pending_rsp_q.size() == 0) begin
				repeat (LATENCY) @(posedge clk);
				if (error_count == 0) begin
					$display("RESULT: OK");
				end else begin
					$display("RESULT: ERROR");
				end
				$finish;
			end
		end
	end

endmodule

>>> sim.f
rtl/core/ialu_pkg.sv
rtl/core/integer_alu_mul_div_branch.sv
dv/integer_alu_mul_div_branch_test.sv
